// ===== hw/rtl/pvr_pkg.sv =====
// pvr_pkg: shared types, constants and microcode for the PI regulator.
// Holds the control word layout and the program ROM read by pvr_seq.
// No dependencies.
`default_nettype none

package pvr_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 40;

  localparam logic [CFG_AW-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_VPC    = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_PGAIN  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_IGAIN  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TOP    = 3'd4;

  localparam logic [21:0] VOLT_MAX = 22'h3F_FFFF;
  localparam logic [16:0] DUTY_ONE = 17'h1_0000;
  localparam logic [15:0] TOP_RST  = 16'hFFFF;

  // integral term saturates here; any value past 2^38 + 2^16 clamps the duty alike
  localparam int          ACC_W   = 42;
  localparam logic [41:0] ACC_SAT = 42'h200_0000_0000;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT = 4'd0;
  localparam step_t ST_OUT  = 4'd13;

  typedef enum logic [2:0] {
    A_ZERO, A_SAMPLE, A_ERRMAG, A_PGAIN, A_KL, A_KH, A_TOPP1
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ZERO, B_VPC, B_LOOP, B_ERRMAG, B_ML, B_MH, B_DUTY
  } b_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_VOLT, WB_INTEG, WB_PTERM, WB_ACC_HI, WB_ACC_ADD, WB_ACC_ADD_HI,
    WB_DUTY, WB_OUT
  } wb_op_t;

  typedef enum logic [1:0] {
    C_NONE, C_NO_INPUT, C_OUT_BUSY
  } jcond_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    wb_op_t wb;
    jcond_t cond;
    step_t  tgt;
    logic   done;
  } ctrl_word_t;

  typedef struct packed {
    logic in_fire;
    logic out_busy;
  } seq_stat_t;

  function automatic ctrl_word_t uw(a_sel_t a, b_sel_t b, wb_op_t wb, jcond_t c,
                                    step_t t, logic d);
    ctrl_word_t w;
    w = '{a_sel: a, b_sel: b, wb: wb, cond: c, tgt: t, done: d};
    return w;
  endfunction

  // product of step n is written back at step n+1
  // last step keeps the level product alive while the output word waits
  function automatic ctrl_word_t uc_word(step_t s);
    ctrl_word_t w;
    case (s)
      4'd0:    w = uw(A_ZERO,   B_ZERO,   WB_NONE,       C_NO_INPUT, ST_WAIT, 1'b0);
      4'd1:    w = uw(A_SAMPLE, B_VPC,    WB_NONE,       C_NONE,     ST_WAIT, 1'b0);
      4'd2:    w = uw(A_ZERO,   B_ZERO,   WB_VOLT,       C_NONE,     ST_WAIT, 1'b0);
      4'd3:    w = uw(A_ERRMAG, B_LOOP,   WB_NONE,       C_NONE,     ST_WAIT, 1'b0);
      4'd4:    w = uw(A_PGAIN,  B_ERRMAG, WB_INTEG,      C_NONE,     ST_WAIT, 1'b0);
      4'd5:    w = uw(A_ZERO,   B_ZERO,   WB_PTERM,      C_NONE,     ST_WAIT, 1'b0);
      4'd6:    w = uw(A_KL,     B_ML,     WB_NONE,       C_NONE,     ST_WAIT, 1'b0);
      4'd7:    w = uw(A_KL,     B_MH,     WB_ACC_HI,     C_NONE,     ST_WAIT, 1'b0);
      4'd8:    w = uw(A_KH,     B_ML,     WB_ACC_ADD,    C_NONE,     ST_WAIT, 1'b0);
      4'd9:    w = uw(A_KH,     B_MH,     WB_ACC_ADD,    C_NONE,     ST_WAIT, 1'b0);
      4'd10:   w = uw(A_ZERO,   B_ZERO,   WB_ACC_ADD_HI, C_NONE,     ST_WAIT, 1'b0);
      4'd11:   w = uw(A_ZERO,   B_ZERO,   WB_DUTY,       C_NONE,     ST_WAIT, 1'b0);
      4'd12:   w = uw(A_TOPP1,  B_DUTY,   WB_NONE,       C_NONE,     ST_WAIT, 1'b0);
      4'd13:   w = uw(A_TOPP1,  B_DUTY,   WB_OUT,        C_OUT_BUSY, ST_OUT,  1'b1);
      default: w = uw(A_ZERO,   B_ZERO,   WB_NONE,       C_NONE,     ST_WAIT, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pvr_seq.sv =====
// pvr_seq: step counter and microcode ROM with conditional jumps.
// Depends on pvr_pkg.
`default_nettype none

module pvr_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  pvr_pkg::seq_stat_t    stat,
  output pvr_pkg::ctrl_word_t   ctrl
);
  import pvr_pkg::*;

  step_t      step_r;
  step_t      step_nxt;
  ctrl_word_t word;
  logic       jump;

  always_comb begin
    word = uc_word(step_r);
    jump = ((word.cond == C_NO_INPUT) && !stat.in_fire) ||
           ((word.cond == C_OUT_BUSY) && stat.out_busy);
    if (jump) begin
      step_nxt = word.tgt;
    end else if (word.done) begin
      step_nxt = ST_WAIT;
    end else begin
      step_nxt = step_r + 1'b1;
    end
    ctrl = word;
    if (jump && (word.cond == C_OUT_BUSY)) begin
      ctrl.wb = WB_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pvr_dp.sv =====
// pvr_dp: shared 32x32 multiplier, PI arithmetic registers and output word.
// Driven by the control word from pvr_seq; depends on pvr_pkg.
`default_nettype none

module pvr_dp #(
  parameter int ADC_BITS      = 12,
  parameter int INTEGRAL_BITS = 48
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  pvr_pkg::ctrl_word_t      ctrl,
  input  wire                      load,
  input  wire [ADC_BITS-1:0]       sample,
  input  wire [15:0]               loop_us,
  input  wire [21:0]               target,
  input  wire [23:0]               vpc,
  input  wire [31:0]               pgain,
  input  wire [39:0]               igain,
  input  wire [15:0]               pwm_top,
  output logic [16:0]              level,
  output logic [16:0]              duty,
  output logic [21:0]              volt
);
  import pvr_pkg::*;

  localparam int IB = INTEGRAL_BITS;
  localparam int SW = ((IB > 40) ? IB : 40) + 1;
  localparam logic signed [SW-1:0] IMAX = {{(SW-IB+1){1'b0}}, {(IB-1){1'b1}}};
  localparam logic signed [SW-1:0] IMIN = ~IMAX;

  logic [ADC_BITS-1:0]  sample_r, sample_nxt;
  logic [15:0]          loop_r, loop_nxt;
  logic [63:0]          prod_r, prod_nxt;
  logic [21:0]          volt_r, volt_nxt;
  logic                 err_neg_r, err_neg_nxt;
  logic [21:0]          err_mag_r, err_mag_nxt;
  logic signed [IB-1:0] integ_r, integ_nxt;
  logic [37:0]          p_mag_r, p_mag_nxt;
  logic                 p_neg_r, p_neg_nxt;
  logic [63:0]          imag_r, imag_nxt;
  logic                 ineg_r, ineg_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [16:0]          duty_r, duty_nxt;
  logic [16:0]          o_level_r, o_level_nxt;
  logic [16:0]          o_duty_r, o_duty_nxt;
  logic [21:0]          o_volt_r, o_volt_nxt;

  logic [31:0]          mul_a, mul_b;
  logic [21:0]          volt_sat;
  logic [22:0]          diff;
  logic [SW-1:0]        inc_mag;
  logic signed [SW-1:0] iext, iinc, isum;
  logic signed [63:0]   i64;
  logic [40:0]          addend;
  logic                 addend_big;
  logic [ACC_W:0]       asum;
  logic signed [43:0]   psg, isg, dsum;

  always_comb begin
    case (ctrl.a_sel)
      A_SAMPLE: mul_a = 32'(sample_r);
      A_ERRMAG: mul_a = 32'(err_mag_r);
      A_PGAIN:  mul_a = pgain;
      A_KL:     mul_a = igain[31:0];
      A_KH:     mul_a = 32'(igain[39:32]);
      A_TOPP1:  mul_a = 32'({1'b0, pwm_top} + 17'd1);
      default:  mul_a = 32'd0;
    endcase
    case (ctrl.b_sel)
      B_VPC:    mul_b = 32'(vpc);
      B_LOOP:   mul_b = 32'(loop_r);
      B_ERRMAG: mul_b = 32'(err_mag_r);
      B_ML:     mul_b = imag_r[31:0];
      B_MH:     mul_b = imag_r[63:32];
      B_DUTY:   mul_b = 32'(duty_r);
      default:  mul_b = 32'd0;
    endcase
    prod_nxt = {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_comb begin
    volt_sat = (|prod_r[63:30]) ? VOLT_MAX : prod_r[29:8];
    diff     = {1'b0, target} - {1'b0, volt_sat};

    inc_mag  = SW'(prod_r[37:0]);
    iext     = SW'(integ_r);
    iinc     = err_neg_r ? -$signed(inc_mag) : $signed(inc_mag);
    isum     = iext + iinc;

    i64      = 64'(integ_r);

    case (ctrl.wb)
      WB_ACC_ADD: begin
        addend     = prod_r[40:0];
        addend_big = |prod_r[63:41];
      end
      WB_ACC_ADD_HI: begin
        addend     = {prod_r[8:0], 32'd0};
        addend_big = |prod_r[63:9];
      end
      default: begin
        addend     = 41'd0;
        addend_big = 1'b0;
      end
    endcase
    asum = {1'b0, acc_r} + {2'b00, addend};

    psg  = p_neg_r ? -$signed(44'(p_mag_r)) : $signed(44'(p_mag_r));
    isg  = ineg_r ? -$signed(44'(acc_r)) : $signed(44'(acc_r));
    dsum = psg + isg;
  end

  always_comb begin
    sample_nxt  = load ? sample : sample_r;
    loop_nxt    = load ? loop_us : loop_r;
    volt_nxt    = volt_r;
    err_neg_nxt = err_neg_r;
    err_mag_nxt = err_mag_r;
    integ_nxt   = integ_r;
    p_mag_nxt   = p_mag_r;
    p_neg_nxt   = p_neg_r;
    imag_nxt    = imag_r;
    ineg_nxt    = ineg_r;
    acc_nxt     = acc_r;
    duty_nxt    = duty_r;
    o_level_nxt = o_level_r;
    o_duty_nxt  = o_duty_r;
    o_volt_nxt  = o_volt_r;
    case (ctrl.wb)
      WB_VOLT: begin
        volt_nxt    = volt_sat;
        err_neg_nxt = diff[22];
        err_mag_nxt = diff[22] ? 22'(-diff) : diff[21:0];
      end
      WB_INTEG: begin
        if (isum > IMAX) begin
          integ_nxt = IB'(IMAX);
        end else if (isum < IMIN) begin
          integ_nxt = IB'(IMIN);
        end else begin
          integ_nxt = IB'(isum);
        end
      end
      WB_PTERM: begin
        p_mag_nxt = prod_r[53:16];
        p_neg_nxt = err_neg_r;
        imag_nxt  = i64[63] ? 64'(-i64) : 64'(i64);
        ineg_nxt  = i64[63];
      end
      WB_ACC_HI: begin
        acc_nxt = ACC_W'(prod_r[63:32]);
      end
      WB_ACC_ADD, WB_ACC_ADD_HI: begin
        acc_nxt = (addend_big || (asum >= {1'b0, ACC_SAT})) ? ACC_SAT : asum[ACC_W-1:0];
      end
      WB_DUTY: begin
        if ((target == 22'd0) || (dsum < 0)) begin
          duty_nxt = 17'd0;
        end else if (dsum > $signed(44'(DUTY_ONE))) begin
          duty_nxt = DUTY_ONE;
        end else begin
          duty_nxt = dsum[16:0];
        end
      end
      WB_OUT: begin
        o_level_nxt = prod_r[32:16];
        o_duty_nxt  = duty_r;
        o_volt_nxt  = volt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
    end else begin
      integ_r <= integ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    loop_r    <= loop_nxt;
    prod_r    <= prod_nxt;
    volt_r    <= volt_nxt;
    err_neg_r <= err_neg_nxt;
    err_mag_r <= err_mag_nxt;
    p_mag_r   <= p_mag_nxt;
    p_neg_r   <= p_neg_nxt;
    imag_r    <= imag_nxt;
    ineg_r    <= ineg_nxt;
    acc_r     <= acc_nxt;
    duty_r    <= duty_nxt;
    o_level_r <= o_level_nxt;
    o_duty_r  <= o_duty_nxt;
    o_volt_r  <= o_volt_nxt;
  end

  assign level = o_level_r;
  assign duty  = o_duty_r;
  assign volt  = o_volt_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pi_voltage_regulator_pwm.sv =====
// pi_voltage_regulator_pwm: PI voltage loop with clamped duty and PWM compare level.
// One input word at a time: in_tready is high only while the microcode program, which shares
// a single 32x32 multiplier, waits at its first step; out_tvalid rises after the last step,
// which holds while the previous output word waits on out_tready.
// Reset: integral cleared, config registers zero except pwm_top = 65535, output empty.
// Uses pvr_pkg, pvr_seq, pvr_dp.
`default_nettype none

module pi_voltage_regulator_pwm #(
  parameter int ADC_BITS      = 12,
  parameter int INTEGRAL_BITS = 48
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // voltage_sample [ADC_BITS-1:0], loop_time_us [ADC_BITS+15:ADC_BITS]
  input  wire [((ADC_BITS+16+7)/8)*8-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // pwm_level [16:0], duty_fraction [33:17], measured_voltage [55:34]
  output logic [55:0]                       out_tdata,
  input  wire                               cfg_wr_en,
  input  wire [pvr_pkg::CFG_AW-1:0]         cfg_addr,
  input  wire [pvr_pkg::CFG_DW-1:0]         cfg_wdata
);
  import pvr_pkg::*;

  logic [21:0] target_r;
  logic [23:0] vpc_r;
  logic [31:0] pgain_r;
  logic [39:0] igain_r;
  logic [15:0] top_r;
  logic        out_tvalid_r, out_tvalid_nxt;

  ctrl_word_t  ctrl;
  seq_stat_t   stat;
  logic [16:0] level, duty;
  logic [21:0] volt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      vpc_r    <= '0;
      pgain_r  <= '0;
      igain_r  <= '0;
      top_r    <= TOP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_TARGET: target_r <= cfg_wdata[21:0];
        CFG_VPC:    vpc_r    <= cfg_wdata[23:0];
        CFG_PGAIN:  pgain_r  <= cfg_wdata[31:0];
        CFG_IGAIN:  igain_r  <= cfg_wdata[39:0];
        CFG_TOP:    top_r    <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready     = (ctrl.cond == C_NO_INPUT);
  assign stat.in_fire  = in_tvalid && in_tready;
  assign stat.out_busy = out_tvalid_r && !out_tready;

  assign out_tvalid_nxt = (ctrl.wb == WB_OUT) || stat.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  pvr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  pvr_dp #(
    .ADC_BITS      (ADC_BITS),
    .INTEGRAL_BITS (INTEGRAL_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .load    (stat.in_fire),
    .sample  (in_tdata[ADC_BITS-1:0]),
    .loop_us (in_tdata[ADC_BITS+15:ADC_BITS]),
    .target  (target_r),
    .vpc     (vpc_r),
    .pgain   (pgain_r),
    .igain   (igain_r),
    .pwm_top (top_r),
    .level   (level),
    .duty    (duty),
    .volt    (volt)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {volt, duty, level};

endmodule

`default_nettype wire

// ===== test/tb_pi_voltage_regulator_pwm.sv =====
// Testbench for pi_voltage_regulator_pwm: directed corners, then randomized loop traffic.
// A scoreboard predicts every result word and compares it against the DUT output.
// Depends on pvr_pkg and the pi_voltage_regulator_pwm RTL.
`default_nettype none

module tb_pi_voltage_regulator_pwm;
  import pvr_pkg::*;

  localparam logic [21:0]    VOLT_SAT  = 22'h3F_FFFF;
  localparam longint         DUTY_FULL = 65536;
  localparam logic [63:0]    ITERM_CAP = 64'd1 << 50;
  localparam longint         INTEG_HI  = (64'sd1 <<< 47) - 64'sd1;
  localparam longint         INTEG_LO  = -INTEG_HI - 64'sd1;

  typedef struct packed {
    logic [15:0] loop_us;
    logic [11:0] sample;
  } sample_word_t;

  typedef struct packed {
    logic [21:0] volts;
    logic [16:0] duty;
    logic [16:0] level;
  } regulation_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // register shadow and integrator copy
  logic [21:0] set_target = '0;
  logic [23:0] set_vpc = '0;
  logic [31:0] set_kp = '0;
  logic [39:0] set_ki = '0;
  logic [15:0] set_top = 16'hFFFF;
  longint integ_acc = 0;

  sample_word_t sample_fifo[$];
  regulation_t expected_regulation[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_in = 0;
  int unsigned words_out = 0;
  int unsigned settings_count = 0;

  pi_voltage_regulator_pwm u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic regulation_t predict_regulation(sample_word_t w);
    logic [63:0] prod_v;
    logic [21:0] volts;
    longint err, incr, p_term, i_term, duty;
    logic [63:0] err_mag, p_mag, integ_mag, i_mag, lvl;
    logic [95:0] i_prod;
    regulation_t r;
    prod_v = ({52'd0, w.sample} * {40'd0, set_vpc}) >> 8;
    volts = (prod_v > {42'd0, VOLT_SAT}) ? VOLT_SAT : prod_v[21:0];
    err = longint'({42'd0, set_target}) - longint'({42'd0, volts});
    incr = err * longint'({48'd0, w.loop_us});
    if (incr > 0 && integ_acc > INTEG_HI - incr) integ_acc = INTEG_HI;
    else if (incr < 0 && integ_acc < INTEG_LO - incr) integ_acc = INTEG_LO;
    else integ_acc = integ_acc + incr;
    err_mag = (err < 0) ? -err : err;
    p_mag = ({32'd0, set_kp} * err_mag) >> 16;
    p_term = (err < 0) ? -longint'(p_mag) : longint'(p_mag);
    integ_mag = (integ_acc < 0) ? -integ_acc : integ_acc;
    i_prod = {56'd0, set_ki} * {32'd0, integ_mag};
    i_mag = (i_prod[95:32] >= {32'd0, ITERM_CAP}) ? ITERM_CAP : i_prod[95:32];
    i_term = (integ_acc < 0) ? -longint'(i_mag) : longint'(i_mag);
    duty = p_term + i_term;
    if (duty > DUTY_FULL) duty = DUTY_FULL;
    if (duty < 0 || set_target == 22'd0) duty = 0;
    lvl = (({48'd0, set_top} + 64'd1) * 64'(duty)) >> 16;
    r.volts = volts;
    r.duty = duty[16:0];
    r.level = lvl[16:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_regulation.push_back(predict_regulation(sample_word_t'(in_tdata[27:0])));
        words_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (sample_fifo.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {4'd0, sample_fifo.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    regulation_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        words_out++;
        if (expected_regulation.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result word: expected none, got %h", $time, got);
        end else begin
          want = expected_regulation.pop_front();
          if (got.level !== want.level) begin
            mismatch_count++;
            $display("%0t pwm_level: expected %0d, got %0d", $time, want.level, got.level);
          end
          if (got.duty !== want.duty) begin
            mismatch_count++;
            $display("%0t duty_fraction: expected %0d, got %0d", $time, want.duty, got.duty);
          end
          if (got.volts !== want.volts) begin
            mismatch_count++;
            $display("%0t measured_voltage: expected %0d, got %0d", $time, want.volts,
                     got.volts);
          end
        end
      end
      out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic logic [39:0] rand_mag(int unsigned maxb);
    int unsigned nb;
    logic [63:0] v;
    nb = $urandom_range(maxb, 0);
    v = {$urandom, $urandom};
    if (nb < 64) v = v & ((64'd1 << nb) - 64'd1);
    return v[39:0];
  endfunction

  function automatic logic [39:0] pick_value(logic [39:0] maxv, int unsigned bits);
    case ($urandom_range(7, 0))
      0: return 40'd0;
      1: return maxv;
      default: return rand_mag(bits);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_TARGET: set_target = val[21:0];
      CFG_VPC:    set_vpc = val[23:0];
      CFG_PGAIN:  set_kp = val[31:0];
      CFG_IGAIN:  set_ki = val[39:0];
      CFG_TOP:    set_top = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [39:0] tgt, logic [39:0] vpc, logic [39:0] kp,
                                logic [39:0] ki, logic [39:0] top);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_VPC, vpc);
    write_reg(CFG_PGAIN, kp);
    write_reg(CFG_IGAIN, ki);
    write_reg(CFG_TOP, top);
    // unmapped index, must be ignored
    write_reg(CFG_TOP + 3'($urandom_range(3, 1)), junk[39:0]);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_count++;
    @(negedge clk);
  endtask

  task automatic queue_word(int unsigned s, int unsigned l);
    sample_word_t w;
    w.sample = s[11:0];
    w.loop_us = l[15:0];
    sample_fifo.push_back(w);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (sample_fifo.size() != 0 || in_tvalid || expected_regulation.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int unsigned s, l;
    send_idle_pct = 15;
    recv_idle_pct = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: zero set-point forces duty off
    queue_word(4095, 65535);
    queue_word(0, 0);
    wait_drained();

    // nominal 5 V loop
    apply_settings(40'd327680, 40'd148653, 40'd6554, 40'd4294967, 40'd1023);
    queue_word(0, 0);
    queue_word(4095, 65535);
    queue_word(2048, 1000);
    queue_word(4095, 0);
    queue_word(0, 65535);
    queue_word(1, 1);
    queue_word(12'hAAA, 16'h5555);
    queue_word(12'h555, 16'hAAAA);
    queue_word(2482, 20000);
    wait_drained();

    // all registers at max, pwm_top zero: voltage overflow and duty clamp
    apply_settings(40'h3F_FFFF, 40'hFF_FFFF, 40'hFFFF_FFFF, 40'hFF_FFFF_FFFF, 40'd0);
    queue_word(4095, 65535);
    queue_word(1, 65535);
    queue_word(0, 0);
    queue_word(4095, 1);
    wait_drained();

    // negative duty and full-scale duty with top at max
    apply_settings(40'd65536, 40'hFF_FFFF, 40'd65536, 40'd0, 40'hFFFF);
    queue_word(4095, 100);
    queue_word(0, 10);
    queue_word(1, 0);
    wait_drained();

    // integral term alone, saturating
    apply_settings(40'h3F_FFFF, 40'd0, 40'd0, 40'hFF_FFFF_FFFF, 40'd32767);
    queue_word(0, 65535);
    queue_word(0, 65535);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 79;
        recv_idle_pct = 15;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(pick_value(40'h3F_FFFF, 22), pick_value(40'hFF_FFFF, 24),
                     pick_value(40'hFFFF_FFFF, 32), pick_value(40'hFF_FFFF_FFFF, 40),
                     pick_value(40'hFFFF, 16));
      for (int i = 0; i < 46; i++) begin
        case ($urandom_range(9, 0))
          0: s = 0;
          1: s = 4095;
          default: s = $urandom_range(4095, 0);
        endcase
        case ($urandom_range(9, 0))
          0: l = 0;
          1: l = 65535;
          2, 3: l = $urandom_range(200, 0);
          default: l = $urandom_range(65535, 0);
        endcase
        queue_word(s, l);
      end
      wait_drained();
    end

    repeat (30) @(negedge clk);
    $display("Run covered %0d input words and %0d result words over %0d register settings,",
             words_in, words_out, settings_count);
    $display("with fixed corner cases first and random gains, set-points and tops after.");
    if (mismatch_count == 0 && expected_regulation.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
